// ===== hw/rtl/hte_pkg.sv =====
// ============================================================================
// hte_pkg - shared types and constants for the heightfield elevation block
// Request payload structs, config register indexes and fixed widths.
// ============================================================================
`default_nettype none

package hte_pkg;

    localparam int GRID_BITS  = 8;
    localparam int FRAC_BITS  = 8;
    localparam int HALF_BITS  = GRID_BITS - 1;  // bank address bits per axis
    localparam int BANK_AW    = 2 * HALF_BITS;

    typedef enum logic [1:0] {
        CFG_INV_CELL = 2'd0,
        CFG_OFF_X    = 2'd1,
        CFG_OFF_Z    = 2'd2,
        CFG_H_OFF    = 2'd3
    } cfg_idx_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_z;
        logic [7:0]         write_x;
        logic [7:0]         write_z;
        logic signed [23:0] height_value;
    } in_req_t;

    typedef struct packed {
        logic signed [24:0] elevation;
        logic               out_of_range;
    } out_req_t;

    // query control carried down the pipeline
    typedef struct packed {
        logic                 oor;
        logic                 par;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fz;
    } qctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hte_bank.sv =====
// ============================================================================
// hte_bank - one parity bank of the height store
// Single write port, single read port, registered read data.
// ============================================================================
`default_nettype none

module hte_bank (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [hte_pkg::BANK_AW-1:0] waddr,
    input  wire logic signed [23:0]      wdata,
    input  wire logic                    re,
    input  wire logic [hte_pkg::BANK_AW-1:0] raddr,
    output logic signed [23:0]           rdata
);
    import hte_pkg::*;

    logic signed [23:0] mem [2**BANK_AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/heightfield_triangle_elevation.sv =====
// A query result passes the stage 0 to stage 3 registers in order; all hold while the output is stalled.
// Throughput: one request per cycle unless the output is stalled; four parity
// banks give all cell corners in one read. Writes give no result.
// A write followed by a query of the same corner: bank write lands before read.
// Reset clears the valid pipeline and loads the config registers with defaults; the height store is not cleared.
// ============================================================================
// heightfield_triangle_elevation - triangle interpolation over a heightfield
// Scales a world position to a grid cell, reads four corners, evaluates the
// triangle plane, subtracts the height offset and saturates the result.
// ============================================================================
`default_nettype none

module heightfield_triangle_elevation (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire hte_pkg::in_req_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output hte_pkg::out_req_t     out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [23:0]      cfg_data
);
    import hte_pkg::*;

    localparam int NST = 4;

    logic [15:0]        inv_cell_reg;
    logic [7:0]         off_x_reg, off_z_reg;
    logic signed [23:0] h_off_reg;

    // pipeline advance: whole pipe moves unless the output is held
    logic adv;
    logic [NST-1:0] v_reg;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign cfg_ready = 1'b1;

    logic acc_in;
    assign acc_in = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_cell_reg <= 16'd13107;
            off_x_reg    <= 8'd20;
            off_z_reg    <= 8'd20;
            h_off_reg    <= 24'sd5120;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_INV_CELL: inv_cell_reg <= cfg_data[15:0];
                CFG_OFF_X:    off_x_reg    <= cfg_data[7:0];
                CFG_OFF_Z:    off_z_reg    <= cfg_data[7:0];
                CFG_H_OFF:    h_off_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: scale multiply ----------------
    logic signed [36:0] px_reg, pz_reg;   // 20s x 17s
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= 37'(in_data.pos_x * $signed({1'b0, inv_cell_reg}));
            pz_reg <= 37'(in_data.pos_z * $signed({1'b0, inv_cell_reg}));
        end
    end

    // bank writes happen at acceptance
    logic [7:0] wx, wz;
    assign wx = in_data.write_x;
    assign wz = in_data.write_z;
    logic wr_en;
    assign wr_en = acc_in && (in_data.opcode == OP_WRITE);

    // ---------------- stage 1: grid coord, split, bank read ----------------
    logic signed [22:0] tx, tz;  // floor(p>>16) + off<<8
    assign tx = 23'(px_reg >>> 16) + $signed({7'd0, off_x_reg, 8'd0});
    assign tz = 23'(pz_reg >>> 16) + $signed({7'd0, off_z_reg, 8'd0});
    logic signed [14:0] cx, cz;
    assign cx = tx[22:8];
    assign cz = tz[22:8];
    logic oor1;
    assign oor1 = cx[14] || cz[14] || (cx > 15'sd254) || (cz > 15'sd254);
    logic [7:0] ux, uz, ux1, uz1;
    assign ux  = cx[7:0];
    assign uz  = cz[7:0];
    assign ux1 = ux + 8'd1;
    assign uz1 = uz + 8'd1;

    // corner (a,b) lies in bank [zpar][xpar]; read addr by bank
    logic [BANK_AW-1:0] raddr [4];
    logic [7:0] bx [2];
    logic [7:0] bz [2];
    always_comb
    begin
        // x of bank with parity p: whichever of ux,ux1 has that parity
        bx[0] = ux[0] ? ux1 : ux;
        bx[1] = ux[0] ? ux : ux1;
        bz[0] = uz[0] ? uz1 : uz;
        bz[1] = uz[0] ? uz : uz1;
        for (int i = 0; i < 4; i++)
        begin
            raddr[i] = {bz[i/2][7:1], bx[i%2][7:1]};
        end
    end

    logic signed [23:0] rd [4];
    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        hte_bank u_bank (
            .clk   (clk),
            .we    (wr_en && ({wz[0], wx[0]} == 2'(g))),
            .waddr ({wz[7:1], wx[7:1]}),
            .wdata (in_data.height_value),
            .re    (adv),
            .raddr (raddr[g]),
            .rdata (rd[g])
        );
    end

    qctl_t q2_reg;
    logic  sx_reg, sz_reg;   // parity of cx, cz
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q2_reg.oor <= oor1;
            q2_reg.par <= ux[0] ^ uz[0];
            q2_reg.fx  <= tx[7:0];
            q2_reg.fz  <= tz[7:0];
            sx_reg     <= ux[0];
            sz_reg     <= uz[0];
        end
    end

    // ---------------- stage 2: triangle select, deltas ----------------
    logic signed [23:0] h00, h10, h01, h11;
    assign h00 = rd[{sz_reg, sx_reg}];
    assign h10 = rd[{sz_reg, !sx_reg}];
    assign h01 = rd[{!sz_reg, sx_reg}];
    assign h11 = rd[{!sz_reg, !sx_reg}];

    logic lower;
    logic signed [25:0] base, dx, dz;
    always_comb
    begin
        if (!q2_reg.par)
        begin
            lower = q2_reg.fz < q2_reg.fx;
        end
        else
        begin
            lower = {1'b0, q2_reg.fz} < (9'd256 - {1'b0, q2_reg.fx});
        end
        base = 26'(h00);
        if (!q2_reg.par)
        begin
            dx = lower ? 26'(h10) - 26'(h00) : 26'(h11) - 26'(h01);
            dz = lower ? 26'(h11) - 26'(h10) : 26'(h01) - 26'(h00);
        end
        else if (lower)
        begin
            dx = 26'(h10) - 26'(h00);
            dz = 26'(h01) - 26'(h00);
        end
        else
        begin
            base = 26'(h10) + 26'(h01) - 26'(h11);
            dx   = 26'(h11) - 26'(h01);
            dz   = 26'(h11) - 26'(h10);
        end
    end

    qctl_t q3_reg;
    logic signed [34:0] mx_reg, mz_reg;
    logic signed [25:0] base_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q3_reg   <= q2_reg;
            base_reg <= base;
            mx_reg   <= 35'(dx * $signed({1'b0, q2_reg.fx}));
            mz_reg   <= 35'(dz * $signed({1'b0, q2_reg.fz}));
        end
    end

    // ---------------- stage 3: sum, round, offset, saturate ----------------
    logic signed [36:0] acc;
    logic signed [28:0] e;
    logic signed [24:0] el;
    always_comb
    begin
        acc = ($signed({base_reg, 8'd0}) + 37'(mx_reg)) + 37'(mz_reg) + 37'sd128;
        e   = 29'(acc >>> 8) - 29'(h_off_reg);
        if (e > 29'sd16777215)
        begin
            el = 25'sd16777215;
        end
        else if (e < -29'sd16777216)
        begin
            el = -25'sd16777216;
        end
        else
        begin
            el = e[24:0];
        end
        if (q3_reg.oor)
        begin
            el = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NST-2:0], acc_in && (in_data.opcode == OP_QUERY)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data.elevation    <= el;
            out_data.out_of_range <= q3_reg.oor;
        end
    end
    assign out_valid = v_reg[NST-1];

endmodule

`default_nettype wire

// ===== hw/rtl/hte_checker.sv =====
// ============================================================================
// hte_checker - port-level checks for the heightfield elevation block
// Handshake holding and result sanity.
// ============================================================================
`default_nettype none

module hte_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic             in_stall,
    input wire hte_pkg::out_req_t out_data
);
    import hte_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_of_range |-> out_data.elevation == '0)
        else $error("out of range result not zero");

    a_backpr: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind heightfield_triangle_elevation hte_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_data  (out_data)
);

`default_nettype wire
